FILE: rtl/core/trr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trr_pkg: shared types and constants of the timecode rate rescaler
// Widths, register map, status codes and sequencer states.
// ----------------------------------------------------------------------------
package trr_pkg;

  // signed width a rescaled count has to fit in
  localparam int unsigned COUNT_WIDTH = 64;
  // frame count port width
  localparam int unsigned FC_W        = 64;
  // edit rate register width
  localparam int unsigned RATE_W      = 31;
  // serial multiplier operand / product widths
  localparam int unsigned MUL_W       = 32;
  localparam int unsigned PROD_W      = 2 * MUL_W;
  // serial divider width
  localparam int unsigned DIV_W       = 64;
  // APB
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;

  // magnitude / multiplier limit
  localparam logic [FC_W-1:0] LIMIT32 = 64'h0000_0000_ffff_ffff;
  // largest magnitudes a signed COUNT_WIDTH value can take
  localparam logic [FC_W-1:0] POS_MAX = (FC_W'(1) << (COUNT_WIDTH - 1)) - FC_W'(1);
  localparam logic [FC_W-1:0] NEG_MAX = FC_W'(1) << (COUNT_WIDTH - 1);

  // register reset values
  localparam logic [RATE_W-1:0] SRC_NUM_RST = RATE_W'(25);
  localparam logic [RATE_W-1:0] SRC_DEN_RST = RATE_W'(1);
  localparam logic [RATE_W-1:0] TGT_NUM_RST = RATE_W'(25);
  localparam logic [RATE_W-1:0] TGT_DEN_RST = RATE_W'(1);

  // register index (byte address / 4)
  typedef enum logic [1:0] {
    REG_SRC_NUM,
    REG_SRC_DEN,
    REG_TGT_NUM,
    REG_TGT_DEN
  } reg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK,
    STAT_ZERO_SRC_NUM,
    STAT_ZERO_TGT_DEN,
    STAT_OVERFLOW
  } status_e;

  // sequencer states: rate reduction first, then per-request work
  typedef enum logic [3:0] {
    ST_PREP_GCD_S,
    ST_PREP_DIV_SN,
    ST_PREP_DIV_SD,
    ST_PREP_GCD_T,
    ST_PREP_DIV_TN,
    ST_PREP_DIV_TD,
    ST_PREP_MUL_M,
    ST_PREP_MUL_D,
    ST_IDLE,
    ST_RUN_MUL,
    ST_RUN_DIV,
    ST_RESULT
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/core/timecode_rate_rescaler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: zero, error, equal-rate and range cases go from request straight to the result state;
//   all others run a 32-step serial multiply, then a 64-step serial divide.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: rates return to 25/1; the rate reduction (two binary GCDs, four divides,
//   two multiplies on the shared units) then runs with input stalled. The same
//   reduction reruns after every register write.
// ----------------------------------------------------------------------------
// timecode_rate_rescaler_unit: rational edit rate rescaler for frame counts
// Reduces the configured rates once per configuration, then scales each count by mul / div.
// ----------------------------------------------------------------------------
module timecode_rate_rescaler_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [trr_pkg::ADDR_W-1:0] paddr,
  input  logic [trr_pkg::DATA_W-1:0] pwdata,
  output logic [trr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [trr_pkg::FC_W-1:0]   frame_count_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [trr_pkg::FC_W-1:0]   scaled_count_o,
  output logic [1:0]                 status_o
);
  import trr_pkg::*;

  state_e            state_q, state_d;
  logic              launch, start_q;

  logic [RATE_W-1:0] src_num_q, src_den_q, tgt_num_q, tgt_den_q;
  logic [RATE_W-1:0] g_q, rsn_q, rsd_q, rtn_q, rtd_q;
  logic [61:0]       mf_q, dv_q;
  logic [MUL_W-1:0]  mag_q;
  logic              neg_q;
  logic [FC_W-1:0]   work_q, res_q, scaled_q;
  status_e           stat_q, status_q;
  logic              out_valid_q;

  logic              cfg_wr, in_acc, out_free;
  logic              rates_eq, mul_ovf;
  logic [FC_W-1:0]   mag_in;
  logic              early;
  logic [FC_W-1:0]   early_res;
  status_e           early_stat;
  logic              q_ovf;
  logic [FC_W-1:0]   q_signed;

  // shared unit hookup
  logic                gcd_start, gcd_done, gcd_fin;
  logic [RATE_W-1:0]   gcd_a, gcd_b, gcd_g;
  logic                mul_start, mul_done, mul_fin;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_prod;
  logic                div_start, div_done, div_fin;
  logic [DIV_W-1:0]    div_n, div_d, div_quo;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SRC_NUM: prdata = {1'b0, src_num_q};
      REG_SRC_DEN: prdata = {1'b0, src_den_q};
      REG_TGT_NUM: prdata = {1'b0, tgt_num_q};
      REG_TGT_DEN: prdata = {1'b0, tgt_den_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_num_q <= SRC_NUM_RST;
      src_den_q <= SRC_DEN_RST;
      tgt_num_q <= TGT_NUM_RST;
      tgt_den_q <= TGT_DEN_RST;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_SRC_NUM: src_num_q <= pwdata[RATE_W-1:0];
        REG_SRC_DEN: src_den_q <= pwdata[RATE_W-1:0];
        REG_TGT_NUM: tgt_num_q <= pwdata[RATE_W-1:0];
        REG_TGT_DEN: tgt_den_q <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // a done pulse in the start cycle belongs to an aborted run
  assign gcd_fin = gcd_done && !start_q;
  assign mul_fin = mul_done && !start_q;
  assign div_fin = div_done && !start_q;

  // reduced-rate facts
  assign rates_eq = (rsn_q == rtn_q) && (rsd_q == rtd_q);
  assign mul_ovf  = |mf_q[61:32];

  // checks that settle a request without arithmetic
  assign mag_in = frame_count_i[FC_W-1] ? (FC_W'(0) - frame_count_i) : frame_count_i;

  always_comb begin
    early      = 1'b1;
    early_res  = '0;
    early_stat = STAT_OK;
    if (frame_count_i == '0) begin
      early_stat = STAT_OK;
    end else if (src_num_q == '0) begin
      early_stat = STAT_ZERO_SRC_NUM;
    end else if (tgt_den_q == '0) begin
      early_stat = STAT_ZERO_TGT_DEN;
    end else if (rates_eq) begin
      early_res  = frame_count_i;
    end else if ((mag_in > LIMIT32) || mul_ovf) begin
      early_stat = STAT_OVERFLOW;
    end else begin
      early = 1'b0;
    end
  end

  // final range check and sign
  assign q_ovf    = neg_q ? (div_quo > NEG_MAX) : (div_quo > POS_MAX);
  assign q_signed = neg_q ? (FC_W'(0) - div_quo) : div_quo;

  // unit operand selection
  assign gcd_start = start_q && ((state_q == ST_PREP_GCD_S) || (state_q == ST_PREP_GCD_T));
  assign gcd_a     = (state_q == ST_PREP_GCD_S) ? src_num_q : tgt_num_q;
  assign gcd_b     = (state_q == ST_PREP_GCD_S) ? src_den_q : tgt_den_q;

  assign mul_start = start_q && ((state_q == ST_PREP_MUL_M) || (state_q == ST_PREP_MUL_D) ||
                                 (state_q == ST_RUN_MUL));

  always_comb begin
    case (state_q)
      ST_PREP_MUL_M: begin
        mul_a = {1'b0, rsd_q};
        mul_b = {1'b0, rtn_q};
      end
      ST_PREP_MUL_D: begin
        mul_a = {1'b0, rsn_q};
        mul_b = {1'b0, rtd_q};
      end
      default: begin
        mul_a = mag_q;
        mul_b = mf_q[MUL_W-1:0];
      end
    endcase
  end

  assign div_start = start_q && ((state_q == ST_PREP_DIV_SN) || (state_q == ST_PREP_DIV_SD) ||
                                 (state_q == ST_PREP_DIV_TN) || (state_q == ST_PREP_DIV_TD) ||
                                 (state_q == ST_RUN_DIV));

  always_comb begin
    div_d = {{(DIV_W-RATE_W){1'b0}}, g_q};
    case (state_q)
      ST_PREP_DIV_SN: div_n = {{(DIV_W-RATE_W){1'b0}}, src_num_q};
      ST_PREP_DIV_SD: div_n = {{(DIV_W-RATE_W){1'b0}}, src_den_q};
      ST_PREP_DIV_TN: div_n = {{(DIV_W-RATE_W){1'b0}}, tgt_num_q};
      ST_PREP_DIV_TD: div_n = {{(DIV_W-RATE_W){1'b0}}, tgt_den_q};
      default: begin
        div_n = work_q;
        div_d = {2'b00, dv_q};
      end
    endcase
  end

  // sequencer: next state and unit launch
  always_comb begin
    state_d = state_q;
    launch  = 1'b0;
    if (cfg_wr) begin
      state_d = ST_PREP_GCD_S;
      launch  = 1'b1;
    end else begin
      case (state_q)
        ST_PREP_GCD_S: if (gcd_fin) begin
          state_d = ST_PREP_DIV_SN;
          launch  = 1'b1;
        end
        ST_PREP_DIV_SN: if (div_fin) begin
          state_d = ST_PREP_DIV_SD;
          launch  = 1'b1;
        end
        ST_PREP_DIV_SD: if (div_fin) begin
          state_d = ST_PREP_GCD_T;
          launch  = 1'b1;
        end
        ST_PREP_GCD_T: if (gcd_fin) begin
          state_d = ST_PREP_DIV_TN;
          launch  = 1'b1;
        end
        ST_PREP_DIV_TN: if (div_fin) begin
          state_d = ST_PREP_DIV_TD;
          launch  = 1'b1;
        end
        ST_PREP_DIV_TD: if (div_fin) begin
          state_d = ST_PREP_MUL_M;
          launch  = 1'b1;
        end
        ST_PREP_MUL_M: if (mul_fin) begin
          state_d = ST_PREP_MUL_D;
          launch  = 1'b1;
        end
        ST_PREP_MUL_D: if (mul_fin) begin
          state_d = ST_IDLE;
        end
        ST_IDLE: if (in_acc) begin
          if (early) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_RUN_MUL;
            launch  = 1'b1;
          end
        end
        ST_RUN_MUL: if (mul_fin) begin
          state_d = ST_RUN_DIV;
          launch  = 1'b1;
        end
        ST_RUN_DIV: if (div_fin) begin
          state_d = ST_RESULT;
        end
        ST_RESULT: if (out_free) begin
          state_d = ST_IDLE;
        end
        default: state_d = ST_PREP_GCD_S;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PREP_GCD_S;
      start_q <= 1'b1;
    end else begin
      state_q <= state_d;
      start_q <= launch;
    end
  end

  // capture unit results into the working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_PREP_GCD_S, ST_PREP_GCD_T: if (gcd_fin) g_q <= gcd_g;
      ST_PREP_DIV_SN: if (div_fin) rsn_q <= div_quo[RATE_W-1:0];
      ST_PREP_DIV_SD: if (div_fin) rsd_q <= div_quo[RATE_W-1:0];
      ST_PREP_DIV_TN: if (div_fin) rtn_q <= div_quo[RATE_W-1:0];
      ST_PREP_DIV_TD: if (div_fin) rtd_q <= div_quo[RATE_W-1:0];
      ST_PREP_MUL_M:  if (mul_fin) mf_q <= mul_prod[61:0];
      ST_PREP_MUL_D:  if (mul_fin) dv_q <= mul_prod[61:0];
      ST_IDLE: if (in_acc) begin
        neg_q  <= frame_count_i[FC_W-1];
        mag_q  <= mag_in[MUL_W-1:0];
        res_q  <= early_res;
        stat_q <= early_stat;
      end
      ST_RUN_MUL: if (mul_fin) work_q <= mul_prod;
      ST_RUN_DIV: if (div_fin) begin
        res_q  <= q_ovf ? '0 : q_signed;
        stat_q <= q_ovf ? STAT_OVERFLOW : STAT_OK;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RESULT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESULT) && out_free) begin
      scaled_q <= res_q;
      status_q <= stat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scaled_count_o = scaled_q;
  assign status_o       = status_q;

  // shared arithmetic units
  trr_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (gcd_a),
    .b_i     (gcd_b),
    .done_o  (gcd_done),
    .gcd_o   (gcd_g)
  );

  trr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  trr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

`ifndef ASSERT_OFF
  // errors always come with a zero count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (scaled_count_o == '0))
    else $error("nonzero count with error status");

  // a unit launch is a single-cycle pulse
  a_start_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> !start_q)
    else $error("unit start held for more than one cycle");

  // the scaling divide never sees a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN_DIV) |-> (dv_q != '0))
    else $error("zero divisor in scaling divide");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/trr_gcd.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trr_gcd: binary greatest common divisor
// One shift or one subtract per cycle; a zero result is reported as one.
// ----------------------------------------------------------------------------
module trr_gcd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [trr_pkg::RATE_W-1:0] a_i,
  input  logic [trr_pkg::RATE_W-1:0] b_i,
  output logic                       done_o,
  output logic [trr_pkg::RATE_W-1:0] gcd_o
);
  import trr_pkg::*;

  localparam int unsigned K_W = $clog2(RATE_W);

  logic [RATE_W-1:0] a_q, a_d, b_q, b_d, g_q, g_d;
  logic [K_W-1:0]    k_q, k_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic              fin;
  logic [RATE_W-1:0] rest;

  assign fin  = busy_q && ((a_q == '0) || (b_q == '0));
  assign rest = a_q | b_q;

  // one reduction step per cycle
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    g_d    = g_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (fin) begin
      busy_d = 1'b0;
      g_d    = (rest == '0) ? RATE_W'(1) : (rest << k_q);
    end else if (busy_q) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + K_W'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q >= b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
    done_d = !start_i && fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule
`default_nettype wire

FILE: rtl/core/trr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trr_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle from a product shift register.
// ----------------------------------------------------------------------------
module trr_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [trr_pkg::MUL_W-1:0]  a_i,
  input  logic [trr_pkg::MUL_W-1:0]  b_i,
  output logic                       done_o,
  output logic [trr_pkg::PROD_W-1:0] prod_o
);
  import trr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_W);

  logic [MUL_W-1:0]  a_q, a_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic              fin;
  logic [MUL_W:0]    sum;

  assign fin = busy_q && (cnt_q == CNT_W'(MUL_W - 1));
  // add multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, prod_q[PROD_W-1:MUL_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    a_d    = a_q;
    prod_d = prod_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d    = a_i;
      prod_d = {{MUL_W{1'b0}}, b_i};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[MUL_W-1:1]};
      cnt_d  = cnt_q + CNT_W'(1);
      if (fin) begin
        busy_d = 1'b0;
      end
    end
    done_d = !start_i && fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule
`default_nettype wire

FILE: rtl/core/trr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trr_div: bit-serial restoring divider
// Shifts the dividend through the remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [trr_pkg::DIV_W-1:0] dividend_i,
  input  logic [trr_pkg::DIV_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [trr_pkg::DIV_W-1:0] quotient_o
);
  import trr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] dvs_q, dvs_d, rem_q, rem_d, quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             fin;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             ge;

  assign fin     = busy_q && (cnt_q == CNT_W'(DIV_W - 1));
  // trial subtract of the divisor from the shifted remainder
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = !diff[DIV_W+1];

  always_comb begin
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (fin) begin
        busy_d = 1'b0;
      end
    end
    done_d = !start_i && fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire
